### rtl/ircs_pkg.sv
package ircs_pkg;

	localparam int unsigned AddrWidth = 32;
	localparam int unsigned RemWidth  = AddrWidth + 1;
	localparam int unsigned PosWidth  = 6;
	localparam int unsigned CntWidth  = 6;

	// Index of the last block a run may emit. The largest split of a range
	// ends exactly at this index, so the bound only forces the final mark.
	localparam logic [CntWidth-1:0] LastCount = 6'd61;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic step;
	} dp_cmd_t;

	typedef struct packed {
		logic range_bad;
		logic last;
	} dp_status_t;

	// Number of trailing zeros of an address; an address of zero gives the full width.
	function automatic logic [PosWidth-1:0] trailing_zeros(input logic [AddrWidth-1:0] v);
		logic [PosWidth-1:0] pos;
		pos = PosWidth'(AddrWidth);
		for (int i = AddrWidth - 1; i >= 0; i--) begin
			if (v[i]) begin
				pos = PosWidth'(i);
			end
		end
		return pos;
	endfunction

	// Position of the highest set bit of a nonzero remaining count.
	function automatic logic [PosWidth-1:0] top_one(input logic [RemWidth-1:0] v);
		logic [PosWidth-1:0] pos;
		pos = '0;
		for (int i = 0; i < RemWidth; i++) begin
			if (v[i]) begin
				pos = PosWidth'(i);
			end
		end
		return pos;
	endfunction

endpackage

### rtl/ircs_ctrl.sv
module ircs_ctrl
	import ircs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t status,
	output dp_cmd_t    cmd,
	output logic       busy
);

	ctrl_state_t state_q;
	ctrl_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && !status.range_bad) begin
					state_next = ST_RUN;
				end
			end
			ST_RUN: begin
				if (status.last) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.load = 1'b0;
		cmd.step = 1'b0;
		busy     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = start && !status.range_bad;
			end
			ST_RUN: begin
				cmd.step = 1'b1;
				busy     = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

### rtl/ircs_datapath.sv
module ircs_datapath
	import ircs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	input  logic [AddrWidth-1:0] range_start,
	input  logic [AddrWidth-1:0] range_end,
	output dp_status_t           status,
	output logic [AddrWidth-1:0] block_base,
	output logic [AddrWidth-1:0] block_mask,
	output logic                 last_block,
	output logic                 block_valid
);

	logic [AddrWidth-1:0] cur_q;
	logic [RemWidth-1:0]  rem_q;
	logic [CntWidth-1:0]  cnt_q;
	logic [AddrWidth-1:0] base_q;
	logic [AddrWidth-1:0] mask_q;
	logic                 last_q;
	logic                 valid_q;

	logic [PosWidth-1:0]  align_pos;
	logic [PosWidth-1:0]  fit_pos;
	logic [PosWidth-1:0]  blk_pos;
	logic [RemWidth-1:0]  blk_size;
	logic [RemWidth-1:0]  host_bits;
	logic [RemWidth-1:0]  load_rem;
	logic                 step_last;

	// The block size is bounded by the alignment of the current address and by
	// the largest power of two that fits in the addresses still to be covered.
	assign align_pos = trailing_zeros(cur_q);
	assign fit_pos   = top_one(rem_q);
	assign blk_pos   = (align_pos < fit_pos) ? align_pos : fit_pos;
	assign blk_size  = RemWidth'(1) << blk_pos;
	assign host_bits = blk_size - RemWidth'(1);
	assign step_last = (rem_q == blk_size) || (cnt_q == LastCount);

	assign load_rem = {1'b0, range_end} - {1'b0, range_start} + RemWidth'(1);

	assign status.range_bad = range_start > range_end;
	assign status.last      = step_last;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q <= range_start;
			rem_q <= load_rem;
			cnt_q <= '0;
		end else if (cmd.step) begin
			cur_q <= cur_q + blk_size[AddrWidth-1:0];
			rem_q <= rem_q - blk_size;
			cnt_q <= cnt_q + CntWidth'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			base_q <= cur_q;
			mask_q <= ~host_bits[AddrWidth-1:0];
			last_q <= step_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.step;
		end
	end

	assign block_base  = base_q;
	assign block_mask  = mask_q;
	assign last_block  = last_q;
	assign block_valid = valid_q;

endmodule

### rtl/ip_range_to_cidr_split.sv
// Splits an inclusive IPv4 address range into the shortest ordered run of
// aligned prefix blocks that covers it exactly, lowest address first.
// A transaction on the input side is accepted at a rising clock edge where
// start is high and busy is low; range_start and range_end are sampled there.
// A range whose start lies above its end is taken and dropped with no result,
// and busy stays low, so another range can follow in the next cycle.
// Each block appears on block_base, block_mask and last_block for exactly one
// cycle while block_valid is high. The receiver cannot stall: every result
// transaction completes in the cycle it is shown.
// The accepting edge loads the current address, the remaining count and the
// run state; the first block then comes from the output registers, and one
// block follows in each cycle after it; last_block marks the final one. A
// range keeps busy high while its blocks, at most 62, are stepped out. Each
// block is worked out combinationally from the trailing zeros of the current
// address and the highest set bit of the remaining count, then registered.
// The last result may still be on the output while the next range is taken.
// Reset returns the controller to idle and clears block_valid; no clearing
// pass is needed.
module ip_range_to_cidr_split
	import ircs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [AddrWidth-1:0] range_start,
	input  logic [AddrWidth-1:0] range_end,
	output logic                 block_valid,
	output logic [AddrWidth-1:0] block_base,
	output logic [AddrWidth-1:0] block_mask,
	output logic                 last_block
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// The controller sequences load and step commands; it sees the datapath
	// only through the range check and the last-block flag.
	ircs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// The datapath holds the current address and the remaining count and
	// registers one block per step.
	ircs_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.range_start (range_start),
		.range_end   (range_end),
		.status      (status),
		.block_base  (block_base),
		.block_mask  (block_mask),
		.last_block  (last_block),
		.block_valid (block_valid)
	);

endmodule

### dv/cidr_block_checker.sv
`timescale 1ns / 1ps

// Watches the range input and the block output of the splitter, works out the
// blocks that each accepted range must produce and checks them in order.
module cidr_block_checker
	import ircs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic [AddrWidth-1:0] range_start,
	input  logic [AddrWidth-1:0] range_end,
	input  logic                 block_valid,
	input  logic [AddrWidth-1:0] block_base,
	input  logic [AddrWidth-1:0] block_mask,
	input  logic                 last_block,
	output int unsigned          fail_count,
	output int unsigned          blocks_pending
);

	typedef struct packed {
		logic [AddrWidth-1:0] base;
		logic [AddrWidth-1:0] mask;
		logic                 last;
	} cidr_block_t;

	localparam logic [AddrWidth:0] AllOnes = {1'b0, {AddrWidth{1'b1}}};

	cidr_block_t expected_blocks[$];

	// Greedy split: at each address take the widest aligned block that stays
	// inside the range, and stop on the block that reaches the range end or at LastCount.
	function automatic void split_range(input logic [AddrWidth-1:0] lo,
			input logic [AddrWidth-1:0] hi);
		logic [AddrWidth:0] cur;
		logic [AddrWidth:0] host;
		logic [AddrWidth:0] wider;
		logic [AddrWidth:0] top;
		cidr_block_t        blk;
		int                 n;
		logic               done;
		if (lo > hi) begin
			return;
		end
		cur = {1'b0, lo};
		n = 0;
		while (n <= int'(LastCount)) begin
			host = '0;
			while (host < AllOnes) begin
				wider = (host << 1) | 1;
				if ((cur & wider) != 0 || (cur | wider) > {1'b0, hi}) begin
					break;
				end
				host = wider;
			end
			top = cur | host;
			done = (top >= {1'b0, hi}) || (n == int'(LastCount));
			blk.base = cur[AddrWidth-1:0];
			blk.mask = ~host[AddrWidth-1:0];
			blk.last = done;
			expected_blocks.push_back(blk);
			n++;
			if (done) begin
				break;
			end
			cur = top + 1;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		cidr_block_t want;
		int unsigned errs;
		if (!arst_n) begin
			expected_blocks.delete();
			fail_count     <= 0;
			blocks_pending <= 0;
		end else begin
			errs = 0;
			// Results of a range always trail its acceptance, so compare first.
			if (block_valid) begin
				if (expected_blocks.size() == 0) begin
					$display("%0t: unexpected block base=%h mask=%h last=%b",
						$time, block_base, block_mask, last_block);
					errs++;
				end else begin
					want = expected_blocks.pop_front();
					if (block_base !== want.base) begin
						$display("%0t: block_base expected %h actual %h",
							$time, want.base, block_base);
						errs++;
					end
					if (block_mask !== want.mask) begin
						$display("%0t: block_mask expected %h actual %h",
							$time, want.mask, block_mask);
						errs++;
					end
					if (last_block !== want.last) begin
						$display("%0t: last_block expected %b actual %b",
							$time, want.last, last_block);
						errs++;
					end
				end
			end
			if (start && !busy) begin
				split_range(range_start, range_end);
			end
			fail_count     <= fail_count + errs;
			blocks_pending <= expected_blocks.size();
		end
	end

endmodule

### dv/tb_ip_range_to_cidr_split.sv
`timescale 1ns / 1ps

// Testbench for the range-to-prefix-block splitter.
// The top only makes stimulus and gives the verdict. All checking happens in
// the checker module, which sees the same ports as the block and reports a
// running failure count and the number of blocks still owed by the block.
module tb_ip_range_to_cidr_split
	import ircs_pkg::*;
();

	localparam logic [AddrWidth-1:0] TopAddr = {AddrWidth{1'b1}};

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [AddrWidth-1:0] range_start;
	logic [AddrWidth-1:0] range_end;
	logic                 block_valid;
	logic [AddrWidth-1:0] block_base;
	logic [AddrWidth-1:0] block_mask;
	logic                 last_block;
	int unsigned          fail_count;
	int unsigned          blocks_pending;

	// Sender idling is switched off for a long stretch of the random part so
	// that back-to-back transactions are exercised as well.
	bit                   sender_may_idle;

	ip_range_to_cidr_split u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.range_start(range_start),
		.range_end  (range_end),
		.block_valid(block_valid),
		.block_base (block_base),
		.block_mask (block_mask),
		.last_block (last_block)
	);

	cidr_block_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.range_start   (range_start),
		.range_end     (range_end),
		.block_valid   (block_valid),
		.block_base    (block_base),
		.block_mask    (block_mask),
		.last_block    (last_block),
		.fail_count    (fail_count),
		.blocks_pending(blocks_pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The time limit is many times what a correct run needs, even if every range
	// split into the maximum of 62 blocks.
	initial begin
		#2ms;
		$display("tb_ip_range_to_cidr_split failed");
		$finish;
	end

	// Presents one range and returns at the edge that accepts it. The start
	// line stays high on return, so the next call either keeps it high with
	// new data or drops it for an idle gap; either way it gets one update
	// per edge.
	task automatic send_range(input logic [AddrWidth-1:0] lo,
			input logic [AddrWidth-1:0] hi);
		if (sender_may_idle && $urandom_range(0, 99) < 11) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start       <= 1'b1;
		range_start <= lo;
		range_end   <= hi;
		// Busy is sampled before the block updates it at this edge, which is
		// exactly the condition under which the block takes the transaction.
		do @(posedge clk); while (busy);
	endtask

	// Holds the sender off until every block owed so far has come out.
	task automatic drain_blocks();
		start <= 1'b0;
		do @(posedge clk); while (blocks_pending != 0);
	endtask

	// Draws a random range. Most draws are valid ranges of several shapes:
	// arbitrary spans, short spans, exact aligned blocks and spans that end at
	// or near the top address. The rest have the start above the end.
	task automatic pick_range(output logic [AddrWidth-1:0] lo,
			output logic [AddrWidth-1:0] hi);
		logic [AddrWidth-1:0] a;
		logic [AddrWidth-1:0] b;
		logic [AddrWidth-1:0] low_bits;
		int unsigned          kind;
		int unsigned          span;
		a = $urandom;
		b = $urandom;
		kind = $urandom_range(0, 99);
		span = $urandom_range(0, 1000);
		low_bits = (32'h1 << $urandom_range(0, 31)) - 1;
		if (kind < 40) begin
			lo = (a < b) ? a : b;
			hi = (a < b) ? b : a;
		end else if (kind < 60) begin
			// Short span, clipped at the top of the address space.
			lo = a;
			hi = (a > TopAddr - span) ? TopAddr : a + span;
		end else if (kind < 75) begin
			// A range that is itself one aligned block.
			lo = a & ~low_bits;
			hi = lo | low_bits;
		end else if (kind < 88) begin
			// Ends at or just below the top address, so the last block may
			// touch it; the start is spread over many magnitudes.
			hi = TopAddr - $urandom_range(0, 2);
			lo = a >> $urandom_range(0, 31);
			if (lo > hi) begin
				lo = hi;
			end
		end else begin
			// Start above end: the block takes it and produces nothing.
			if (a == b) begin
				b = a ^ 32'h1;
			end
			lo = (a > b) ? a : b;
			hi = (a > b) ? b : a;
		end
	endtask

	initial begin : stimulus
		logic [AddrWidth-1:0] lo;
		logic [AddrWidth-1:0] hi;
		arst_n          <= 1'b0;
		start           <= 1'b0;
		range_start     <= '0;
		range_end       <= '0;
		sender_may_idle = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: single addresses at both ends of the space, the whole
		// space, a start above the end, the split with the most blocks, ranges
		// that end at the top address, and a few ordinary cases.
		send_range(32'h0000_0000, 32'h0000_0000);
		send_range(TopAddr, TopAddr);
		send_range(32'h0000_0000, TopAddr);
		send_range(32'h0000_0001, 32'h0000_0000);
		send_range(TopAddr, 32'h0000_0000);
		send_range(32'h0000_0001, TopAddr - 1);
		send_range(32'h0000_0000, TopAddr - 1);
		send_range(32'h0000_0001, TopAddr);
		send_range(32'h8000_0000, TopAddr);
		send_range(32'h0000_0005, TopAddr);
		send_range(TopAddr - 1, TopAddr);
		send_range(32'h0A00_0000, 32'h0A00_00FF);
		send_range(32'hC0A8_0001, 32'hC0A8_01FE);
		send_range(32'h7FFF_FFFF, 32'h8000_0000);
		send_range(32'h5555_5555, 32'hAAAA_AAAA);
		send_range(32'hAAAA_AAAA, 32'h5555_5555);
		send_range(32'h0000_0001, 32'h7FFF_FFFF);
		send_range(32'h8000_0001, 32'hFFFF_FFFE);
		send_range(32'h1234_5678, 32'h1234_5678);

		// Let everything drain once before the random part starts.
		drain_blocks();

		for (int i = 0; i < 211; i++) begin
			sender_may_idle = !(i >= 60 && i < 130);
			if (i == 170) begin
				drain_blocks();
			end
			pick_range(lo, hi);
			send_range(lo, hi);
		end

		// Wait until nothing is owed, then keep the clock running so that any stray
		// block after the last expected one is still caught.
		drain_blocks();
		repeat (10) @(posedge clk);

		if (fail_count == 0 && blocks_pending == 0) begin
			$display("tb_ip_range_to_cidr_split passed");
		end else begin
			$display("tb_ip_range_to_cidr_split failed");
		end
		$finish;
	end

endmodule
